### sv/pce_pkg.sv
// Package for the Pearson correlation engine: widths, the per-set sums record
// and the back-end sequencer states. No dependencies.
package pce_pkg;

  // Field and accumulator widths
  localparam int SMP_W    = 16;   // Q8.8 sample
  localparam int CNT_W    = 11;   // pair counter
  localparam int CNT_MAX  = 2047;
  localparam int SUM_W    = 27;   // sum of x, sum of y
  localparam int SXY_W    = 42;   // sum of x*y (signed)
  localparam int SSQ_W    = 41;   // sum of squares (unsigned)
  localparam int PRD_W    = 54;   // n*sum and sum*sum products
  localparam int DIFF_W   = 56;   // C, A, B (signed)
  localparam int MAG_W    = 55;   // |C|, A, B magnitude
  localparam int WIDE_W   = 110;  // C^2 and A*B
  localparam int RATIO_W  = 31;   // floor(2^30 * C^2 / (A*B))
  localparam int ROOT_W   = 16;
  localparam int DIV_DW   = 56;   // shared divider dividend
  localparam int DIV_VW   = 22;   // shared divider divisor
  localparam int COV_W    = 32;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 96;
  localparam int QUEUE_DEPTH = 2;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_PAIRS    = 1024;
  localparam int DEF_SAMPLE_WIDTH = 16;

  // Everything the back end needs about one finished data set
  typedef struct packed {
    logic        [CNT_W-1:0] n;
    logic signed [SUM_W-1:0] sx;
    logic signed [SUM_W-1:0] sy;
    logic signed [SXY_W-1:0] sxy;
    logic        [SSQ_W-1:0] sxx;
    logic        [SSQ_W-1:0] syy;
  } sums_t;

  // Back-end sequencer
  typedef enum logic [3:0] {
    B_IDLE,
    B_PROD,
    B_MEANX,
    B_MEANY,
    B_COV,
    B_MUL,
    B_RDIV,
    B_SQRT,
    B_OUT
  } back_state_e;

endpackage

### sv/pearson_correlation_engine.sv
// Pearson correlation engine. Pairs (x, y) in signed Q8.8 enter on the slave
// stream one per cycle; tlast closes a data set. For each set one result word
// leaves: pair count, both means, sample covariance (Q16.16, saturated) and
// the coefficient r (Q1.15), with tuser flagging a degenerate set (under two
// pairs or a zero variance, r then 0). The front end accumulates at full rate
// and passes finished sets through a two-deep queue; the back end handles one
// set at a time: up to three passes of the shared restoring divider, two
// shift-add multiplies, a ratio division and a square root, plus set-up.
// Input stalls only when the queue is full, as when short sets arrive faster
// than the back end drains them.
// Depends on pce_pkg, pce_front, pce_queue, pce_div and pce_back.
module pearson_correlation_engine
  import pce_pkg::*;
#(
  parameter int MAX_PAIRS    = DEF_MAX_PAIRS,
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // x_sample[15:0], y_sample[31:16]
  input  logic                   s_axis_tlast,  // last
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // pair_count[10:0], mean_x[26:11],
                                                // mean_y[42:27], covariance[74:43],
                                                // correlation[90:75], zero[95:91]
  output logic                   m_axis_tuser   // degenerate
);

  logic  push, full, pop, rec_valid;
  sums_t rec_in, rec_out;

  pce_front #(
    .MAX_PAIRS    (MAX_PAIRS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .x_i     (s_axis_tdata[SMP_W-1:0]),
    .y_i     (s_axis_tdata[2*SMP_W-1:SMP_W]),
    .last_i  (s_axis_tlast),
    .full_i  (full),
    .push_o  (push),
    .rec_o   (rec_in)
  );

  pce_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (rec_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (rec_valid),
    .data_o  (rec_out)
  );

  pce_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_valid_i (rec_valid),
    .rec_i       (rec_out),
    .pop_o       (pop),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_o    (m_axis_tdata),
    .m_degen_o   (m_axis_tuser)
  );

endmodule

### sv/pce_front.sv
// Front end of the Pearson correlation engine: takes one pair per cycle
// unless the queue is full, keeps the running sums and hands a finished
// set to the queue. Depends on pce_pkg.
module pce_front
  import pce_pkg::*;
#(
  parameter int MAX_PAIRS    = DEF_MAX_PAIRS,
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  logic [SMP_W-1:0]  x_i,
  input  logic [SMP_W-1:0]  y_i,
  input  logic              last_i,
  input  logic              full_i,
  output logic              push_o,
  output sums_t             rec_o
);

  localparam int LIMIT = (MAX_PAIRS > CNT_MAX) ? CNT_MAX : MAX_PAIRS;
  localparam int SW    = (SAMPLE_WIDTH > SMP_W) ? SMP_W : SAMPLE_WIDTH;
  localparam int SHIFT = SMP_W - SW;
  localparam logic [CNT_W-1:0] LIMIT_C = CNT_W'(LIMIT);

  logic        [CNT_W-1:0] cnt_q, cnt_d;
  logic signed [SUM_W-1:0] sx_q, sx_d, sy_q, sy_d;
  logic signed [SXY_W-1:0] sxy_q, sxy_d;
  logic        [SSQ_W-1:0] sxx_q, sxx_d, syy_q, syy_d;

  logic signed [SMP_W-1:0] x_sh, y_sh, x_ext, y_ext;
  logic signed [2*SMP_W-1:0] xy, xx, yy;
  logic accept, take;

  assign ready_o = !full_i;
  assign accept  = valid_i && ready_o;
  assign take    = cnt_q < LIMIT_C;

  // Sign-extend from the configured sample width
  always_comb begin
    x_sh  = x_i << SHIFT;
    y_sh  = y_i << SHIFT;
    x_ext = x_sh >>> SHIFT;
    y_ext = y_sh >>> SHIFT;
    xy    = (2*SMP_W)'(x_ext) * (2*SMP_W)'(y_ext);
    xx    = (2*SMP_W)'(x_ext) * (2*SMP_W)'(x_ext);
    yy    = (2*SMP_W)'(y_ext) * (2*SMP_W)'(y_ext);
  end

  // Sums including the current word
  always_comb begin
    cnt_d = cnt_q;
    sx_d  = sx_q;
    sy_d  = sy_q;
    sxy_d = sxy_q;
    sxx_d = sxx_q;
    syy_d = syy_q;
    if (take) begin
      cnt_d = cnt_q + CNT_W'(1);
      sx_d  = sx_q + SUM_W'(x_ext);
      sy_d  = sy_q + SUM_W'(y_ext);
      sxy_d = sxy_q + SXY_W'(xy);
      sxx_d = sxx_q + SSQ_W'(unsigned'(xx));
      syy_d = syy_q + SSQ_W'(unsigned'(yy));
    end
  end

  assign push_o    = accept && last_i;
  assign rec_o.n   = cnt_d;
  assign rec_o.sx  = sx_d;
  assign rec_o.sy  = sy_d;
  assign rec_o.sxy = sxy_d;
  assign rec_o.sxx = sxx_d;
  assign rec_o.syy = syy_d;

  // Accumulators; cleared once a set is handed on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      sx_q  <= '0;
      sy_q  <= '0;
      sxy_q <= '0;
      sxx_q <= '0;
      syy_q <= '0;
    end else if (accept) begin
      if (last_i) begin
        cnt_q <= '0;
        sx_q  <= '0;
        sy_q  <= '0;
        sxy_q <= '0;
        sxx_q <= '0;
        syy_q <= '0;
      end else begin
        cnt_q <= cnt_d;
        sx_q  <= sx_d;
        sy_q  <= sy_d;
        sxy_q <= sxy_d;
        sxx_q <= sxx_d;
        syy_q <= syy_d;
      end
    end
  end

endmodule

### sv/pce_queue.sv
// Short queue of finished sets between front and back end.
// Depends on pce_pkg.
module pce_queue
  import pce_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  sums_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output sums_t data_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

  sums_t mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [LVL_W-1:0] lvl_q;

  assign full_o  = lvl_q == LVL_W'(QUEUE_DEPTH);
  assign valid_o = lvl_q != '0;
  assign data_o  = mem_q[rd_q];

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      lvl_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        lvl_q <= lvl_q + LVL_W'(1);
      end else if (pop_i && !push_i) begin
        lvl_q <= lvl_q - LVL_W'(1);
      end
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

### sv/pce_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on pce_pkg for its default widths.
module pce_div
  import pce_pkg::*;
#(
  parameter int DW = DIV_DW,
  parameter int VW = DIV_VW
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quot_o
);

  localparam int CW = $clog2(DW + 1);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [VW-1:0] rem_q, dsr_q;
  logic [DW-1:0] quo_q;
  logic [VW:0]   sh, diff;
  logic          ge;

  // One trial subtraction
  always_comb begin
    sh   = {rem_q, quo_q[DW-1]};
    ge   = sh >= {1'b0, dsr_q};
    diff = sh - {1'b0, dsr_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[VW-1:0] : sh[VW-1:0];
      quo_q <= {quo_q[DW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

### sv/pce_back.sv
// Back end of the Pearson correlation engine: turns one set of sums into a
// result word (means, covariance, coefficient) and holds it in the output
// register. Depends on pce_pkg and pce_div.
module pce_back
  import pce_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   rec_valid_i,
  input  sums_t                  rec_i,
  output logic                   pop_o,
  output logic                   m_valid_o,
  input  logic                   m_ready_i,
  output logic [OUT_TDATA_W-1:0] m_data_o,
  output logic                   m_degen_o
);

  localparam int MC_W = $clog2(MAG_W + 1);
  localparam int RC_W = $clog2(RATIO_W + 1);
  localparam int SC_W = $clog2(ROOT_W);

  back_state_e state_q, state_d;

  // Set under work
  logic        [CNT_W-1:0]  n_q;
  logic signed [SUM_W-1:0]  sx_q, sy_q;
  logic signed [SXY_W-1:0]  sxy_q;
  logic        [SSQ_W-1:0]  sxx_q, syy_q;

  logic        [1:0]        step_q;
  logic signed [PRD_W-1:0]  p1_q, p2_q, p1_w, p2_w;
  logic signed [SXY_W-1:0]  op1;
  logic signed [SUM_W-1:0]  op2a, op2b;
  logic signed [CNT_W:0]    n_s;
  logic signed [DIFF_W-1:0] c_q, a_q, b_q, diff_w;
  logic        [DIV_VW-1:0] nn1_q;

  logic [SMP_W-1:0] mx_q, my_q;
  logic [COV_W-1:0] cov_q;

  // Serial multiplier, restoring ratio division and square root
  logic              issued_q, mphase_q;
  logic [MC_W-1:0]   mcnt_q;
  logic [WIDE_W-1:0] acc_q, mcand_q, nsq_q, acc_nxt;
  logic [MAG_W-1:0]  mplier_q;
  logic [RC_W-1:0]   rcnt_q;
  logic [WIDE_W:0]   rem_q, rem_sub;
  logic              rge;
  logic [RATIO_W-1:0] qr_q;
  logic [SC_W-1:0]   sidx_q;
  logic [ROOT_W-1:0] root_q, trial;
  logic [2*ROOT_W-1:0] trial_sq;

  // Divider hookup
  logic              div_start, div_done;
  logic [DIV_DW-1:0] div_dvd, div_quot;
  logic [DIV_VW-1:0] div_dsr;

  logic [SUM_W-1:0]  sx_abs, sy_abs;
  logic [DIFF_W-1:0] c_abs;
  logic              degen, few, out_free, out_load;
  logic              mul_last, rdiv_last, sqrt_last;

  // Output register
  logic                   m_valid_q;
  logic [OUT_TDATA_W-1:0] m_data_q;
  logic                   m_degen_q;
  logic [SMP_W-1:0]       corr;
  logic [COV_W-1:0]       cov_out;

  assign sx_abs = sx_q[SUM_W-1] ? SUM_W'(-sx_q) : SUM_W'(sx_q);
  assign sy_abs = sy_q[SUM_W-1] ? SUM_W'(-sy_q) : SUM_W'(sy_q);
  assign c_abs  = c_q[DIFF_W-1] ? DIFF_W'(-c_q) : DIFF_W'(c_q);
  assign few    = n_q < CNT_W'(2);
  assign degen  = few || (a_q <= 0) || (b_q <= 0);
  assign out_free  = !m_valid_q || m_ready_i;
  assign mul_last  = issued_q && (mcnt_q == MC_W'(1));
  assign rdiv_last = issued_q && (rcnt_q == RC_W'(1));
  assign sqrt_last = issued_q && (sidx_q == '0);

  // Products for C, A and B, one pair per step
  always_comb begin
    n_s  = $signed({1'b0, n_q});
    op1  = sxy_q;
    op2a = sx_q;
    op2b = sy_q;
    unique case (step_q)
      2'd1: begin
        op1  = $signed({1'b0, sxx_q});
        op2b = sx_q;
      end
      2'd2: begin
        op1  = $signed({1'b0, syy_q});
        op2a = sy_q;
      end
      default: begin
        op1 = sxy_q;
      end
    endcase
    p1_w   = PRD_W'(op1) * PRD_W'(n_s);
    p2_w   = PRD_W'(op2a) * PRD_W'(op2b);
    diff_w = DIFF_W'(p1_q) - DIFF_W'(p2_q);
  end

  // Multiply, ratio and root datapath steps
  always_comb begin
    acc_nxt  = acc_q + (mplier_q[0] ? mcand_q : '0);
    rge      = rem_q >= {1'b0, acc_q};
    rem_sub  = rge ? rem_q - {1'b0, acc_q} : rem_q;
    trial    = root_q | (ROOT_W'(1) << sidx_q);
    trial_sq = (2*ROOT_W)'(trial) * (2*ROOT_W)'(trial);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE:  if (rec_valid_i) state_d = B_PROD;
      B_PROD:  if (step_q == 2'd3) state_d = B_MEANX;
      B_MEANX: if (div_done) state_d = B_MEANY;
      B_MEANY: if (div_done) state_d = few ? B_OUT : B_COV;
      B_COV:   if (div_done) state_d = degen ? B_OUT : B_MUL;
      B_MUL:   if (mul_last && mphase_q) state_d = B_RDIV;
      B_RDIV:  if (rdiv_last) state_d = B_SQRT;
      B_SQRT:  if (sqrt_last) state_d = B_OUT;
      B_OUT:   if (out_free) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    pop_o     = 1'b0;
    div_start = 1'b0;
    div_dvd   = DIV_DW'(sx_abs);
    div_dsr   = DIV_VW'(n_q);
    out_load  = 1'b0;
    unique case (state_q)
      B_IDLE:  pop_o = rec_valid_i;
      B_MEANX: div_start = !issued_q;
      B_MEANY: begin
        div_start = !issued_q;
        div_dvd   = DIV_DW'(sy_abs);
      end
      B_COV: begin
        div_start = !issued_q;
        div_dvd   = c_abs;
        div_dsr   = nn1_q;
      end
      B_OUT:   out_load = out_free;
      default: pop_o = 1'b0;
    endcase
  end

  pce_div #(
    .DW(DIV_DW),
    .VW(DIV_VW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= B_IDLE;
      step_q    <= '0;
      issued_q  <= 1'b0;
      mphase_q  <= 1'b0;
      mcnt_q    <= '0;
      rcnt_q    <= '0;
      sidx_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop_o) begin
        step_q <= '0;
      end else if (state_q == B_PROD) begin
        step_q <= step_q + 2'd1;
      end
      if (div_start) begin
        issued_q <= 1'b1;
      end else if (div_done) begin
        issued_q <= 1'b0;
        mphase_q <= 1'b0;
      end
      if (state_q == B_MUL) begin
        if (!issued_q) begin
          issued_q <= 1'b1;
          mcnt_q   <= MC_W'(MAG_W);
        end else begin
          mcnt_q <= mcnt_q - MC_W'(1);
          if (mul_last) begin
            issued_q <= 1'b0;
            mphase_q <= 1'b1;
          end
        end
      end
      if (state_q == B_RDIV) begin
        if (!issued_q) begin
          issued_q <= 1'b1;
          rcnt_q   <= RC_W'(RATIO_W);
        end else begin
          rcnt_q <= rcnt_q - RC_W'(1);
          if (rdiv_last) issued_q <= 1'b0;
        end
      end
      if (state_q == B_SQRT) begin
        if (!issued_q) begin
          issued_q <= 1'b1;
          sidx_q   <= SC_W'(ROOT_W - 1);
        end else begin
          sidx_q <= sidx_q - SC_W'(1);
          if (sqrt_last) issued_q <= 1'b0;
        end
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      n_q   <= rec_i.n;
      sx_q  <= rec_i.sx;
      sy_q  <= rec_i.sy;
      sxy_q <= rec_i.sxy;
      sxx_q <= rec_i.sxx;
      syy_q <= rec_i.syy;
    end
    if (state_q == B_PROD) begin
      p1_q  <= p1_w;
      p2_q  <= p2_w;
      nn1_q <= DIV_VW'(n_q) * DIV_VW'(n_q - CNT_W'(1));
      unique case (step_q)
        2'd1:    c_q <= diff_w;
        2'd2:    a_q <= diff_w;
        2'd3:    b_q <= diff_w;
        default: c_q <= c_q;
      endcase
    end
    // Means and covariance, signs put back on the magnitudes
    if (div_done) begin
      unique case (state_q)
        B_MEANX: mx_q <= sx_q[SUM_W-1] ? -div_quot[SMP_W-1:0] : div_quot[SMP_W-1:0];
        B_MEANY: my_q <= sy_q[SUM_W-1] ? -div_quot[SMP_W-1:0] : div_quot[SMP_W-1:0];
        B_COV: begin
          if (c_q[DIFF_W-1]) begin
            cov_q <= (div_quot > DIV_DW'(64'h8000_0000)) ? 32'h8000_0000
                                                          : -div_quot[COV_W-1:0];
          end else begin
            cov_q <= (div_quot > DIV_DW'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF
                                                          : div_quot[COV_W-1:0];
          end
        end
        default: cov_q <= cov_q;
      endcase
    end
    // C^2 first, then A*B (left in acc_q)
    if (state_q == B_MUL) begin
      if (!issued_q) begin
        acc_q    <= '0;
        mcand_q  <= WIDE_W'(mphase_q ? a_q[MAG_W-1:0] : c_abs[MAG_W-1:0]);
        mplier_q <= mphase_q ? b_q[MAG_W-1:0] : c_abs[MAG_W-1:0];
      end else begin
        acc_q    <= acc_nxt;
        mcand_q  <= mcand_q << 1;
        mplier_q <= mplier_q >> 1;
        if (mul_last && !mphase_q) nsq_q <= acc_nxt;
      end
    end
    // floor(2^30 * C^2 / (A*B)), one bit a cycle
    if (state_q == B_RDIV) begin
      if (!issued_q) begin
        rem_q <= {1'b0, nsq_q};
        qr_q  <= '0;
      end else begin
        rem_q <= {rem_sub[WIDE_W-1:0], 1'b0};
        qr_q  <= {qr_q[RATIO_W-2:0], rge};
      end
    end
    // Integer square root of the ratio
    if (state_q == B_SQRT) begin
      if (!issued_q) begin
        root_q <= '0;
      end else if (trial_sq <= (2*ROOT_W)'(qr_q)) begin
        root_q <= trial;
      end
    end
    if (out_load) begin
      m_data_q  <= {(OUT_TDATA_W - CNT_W - 3*SMP_W - COV_W)'(0),
                    corr, cov_out, my_q, mx_q, n_q};
      m_degen_q <= degen;
    end
  end

  // Coefficient sign and +1 clamp
  always_comb begin
    if (degen) begin
      corr = '0;
    end else if (c_q[DIFF_W-1]) begin
      corr = -root_q;
    end else begin
      corr = root_q[ROOT_W-1] ? 16'h7FFF : root_q;
    end
    cov_out = few ? '0 : cov_q;
  end

  assign m_valid_o = m_valid_q;
  assign m_data_o  = m_data_q;
  assign m_degen_o = m_degen_q;

endmodule

### sv/pce_checker.sv
// Port-level checks for the Pearson correlation engine, bound to the top.
// Depends on pce_pkg.
module pce_checker
  import pce_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tuser
);

  // A stalled result word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // Every set holds at least one pair
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[10:0] != 11'd0)
    else $error("result with zero pairs");

  // A usable coefficient needs two pairs or more
  a_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[10:1] != 10'd0)
    else $error("non-degenerate result with fewer than two pairs");

  // Degenerate sets give a zero coefficient
  a_degen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[90:75] == 16'd0)
    else $error("degenerate result with non-zero coefficient");

endmodule

bind pearson_correlation_engine pce_checker u_pce_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

### bench/tb_pearson_correlation_engine.sv
// Testbench for pearson_correlation_engine: drives (x, y) pair streams, predicts
// count, means, covariance and r per data set, and checks every result word.
// Depends on pce_pkg and the engine RTL.
module tb_pearson_correlation_engine;
  import pce_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_PAIRS = 1024;
  localparam int IDLE_LIMIT  = 30000;

  typedef struct {
    int unsigned      cnt;
    logic signed [15:0] mx;
    logic signed [15:0] my;
    logic signed [31:0] cov;
    logic signed [15:0] corr;
    logic             degen;
  } set_result_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   s_axis_tlast;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;

  // running sums of the set being collected
  int unsigned pair_cnt;
  longint      acc_x, acc_y, acc_xy, acc_xx, acc_yy;

  set_result_t expected_results[$];
  int          mismatches;
  int          words_sent;
  int          sets_checked;
  int          degen_seen;
  int          burst_left;
  int          hold_req;
  bit          no_gaps;

  pearson_correlation_engine dut (.*);

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // fold one pair into the sums; on the last pair, work out the set's result
  task automatic predict_pair(input logic signed [15:0] xs, input logic signed [15:0] ys,
                              input logic lst);
    longint          x, y, n, c, a, b, cv;
    logic [191:0]    prod, rhs, lhs, tt;
    longint unsigned q, t, cmag;
    set_result_t     r;
    x = xs;
    y = ys;
    if (pair_cnt < LIMIT_PAIRS) begin
      acc_x += x;  acc_y += y;
      acc_xy += x * y;  acc_xx += x * x;  acc_yy += y * y;
      pair_cnt++;
    end
    if (!lst) return;
    n = pair_cnt;
    r.cnt = pair_cnt;
    r.mx = 16'((n > 0) ? acc_x / n : 0);
    r.my = 16'((n > 0) ? acc_y / n : 0);
    c = n * acc_xy - acc_x * acc_y;
    a = n * acc_xx - acc_x * acc_x;
    b = n * acc_yy - acc_y * acc_y;
    r.degen = (n < 2) || (a <= 0) || (b <= 0);
    cv = 0;
    if (n >= 2) begin
      cv = c / (n * (n - 1));
      if (cv > 64'sd2147483647) cv = 64'sd2147483647;
      if (cv < -64'sd2147483648) cv = -64'sd2147483648;
    end
    r.cov = cv[31:0];
    r.corr = 0;
    if (!r.degen) begin
      // largest q with q^2 * A * B <= 2^30 * C^2
      cmag = (c < 0) ? -c : c;
      prod = 192'(a) * 192'(b);
      rhs = (192'(cmag) * 192'(cmag)) << 30;
      q = 0;
      for (int bit_i = 16; bit_i >= 0; bit_i--) begin
        t = q | (64'd1 << bit_i);
        tt = 192'(t * t);
        lhs = tt * prod;
        if (lhs <= rhs) q = t;
      end
      if (q > 32768) q = 32768;
      if (c < 0) r.corr = 16'(-longint'(q));
      else r.corr = (q > 32767) ? 16'sd32767 : 16'(q);
    end
    expected_results.push_back(r);
    pair_cnt = 0;
    acc_x = 0; acc_y = 0; acc_xy = 0; acc_xx = 0; acc_yy = 0;
  endtask

  // offer one pair in bursts with random gaps, wait for the handshake
  task automatic send_pair(input logic signed [15:0] xs, input logic signed [15:0] ys,
                           input logic lst);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = no_gaps ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {ys, xs};
    s_axis_tlast  <= lst;
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
    predict_pair(xs, ys, lst);
  endtask

  function automatic logic signed [15:0] rand_sample(int mode);
    case (mode)
      0:       return 16'($urandom);
      1:       return 16'($urandom_range(0, 512)) - 16'sd256;
      default: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
    endcase
  endfunction

  task automatic send_set(int len, int mode);
    logic signed [15:0] xs, ys;
    int                 rel;
    rel = $urandom_range(0, 3);
    for (int i = 0; i < len; i++) begin
      xs = rand_sample(mode);
      // correlated, anti-correlated or independent y
      case (rel)
        0:       ys = xs ^ 16'($urandom_range(0, 15));
        1:       ys = ~xs;
        default: ys = rand_sample(mode);
      endcase
      send_pair(xs, ys, i == len - 1);
    end
  endtask

  task automatic test_directed();
    // single pair at the extremes: under two pairs
    send_pair(16'sh8000, 16'sh7fff, 1'b1);
    // y = x at the extremes: r = +1 saturates
    send_pair(16'sh7fff, 16'sh7fff, 1'b0);
    send_pair(16'sh8000, 16'sh8000, 1'b1);
    // y = -x: r = -1
    send_pair(16'sd1, -16'sd1, 1'b0);
    send_pair(16'sd2, -16'sd2, 1'b0);
    send_pair(16'sd3, -16'sd3, 1'b1);
    // constant x: zero variance
    send_pair(16'sd5, 16'sd1, 1'b0);
    send_pair(16'sd5, 16'sd7, 1'b0);
    send_pair(16'sd5, -16'sd3, 1'b1);
    // constant y: zero variance
    send_pair(-16'sd9, 16'sh8000, 1'b0);
    send_pair(16'sd4, 16'sh8000, 1'b1);
    // mixed extremes and zeros
    send_pair(16'sh7fff, 16'sh8000, 1'b0);
    send_pair(16'sh0000, 16'sh7fff, 1'b0);
    send_pair(16'sh8000, 16'sh0000, 1'b0);
    send_pair(16'shffff, 16'sh0001, 1'b1);
  endtask

  // a set longer than the pair limit; the closing pair is itself ignored
  task automatic test_pair_limit();
    send_set(LIMIT_PAIRS + 6, 0);
  endtask

  // receiver holds off while short sets pile up and stall the input
  task automatic test_backpressure();
    no_gaps = 1'b1;
    hold_req = 2000;
    for (int i = 0; i < 10; i++) send_set(2, $urandom_range(0, 2));
    no_gaps = 1'b0;
  endtask

  task automatic test_random();
    int items;
    int len;
    items = 0;
    while (items < 640) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      send_set(len, $urandom_range(0, 4) == 0 ? 2 : $urandom_range(0, 1));
      items += len;
    end
  endtask

  // result checker and receiver stall pattern
  initial begin
    set_result_t e;
    int          hold_cnt;
    int          stall_pct;
    int          cyc;
    hold_cnt = 0;
    stall_pct = 0;
    cyc = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result word with nothing expected: %h", $time, m_axis_tdata);
          mismatches++;
        end else begin
          e = expected_results.pop_front();
          sets_checked++;
          if (e.degen) degen_seen++;
          if (m_axis_tdata[10:0] != 11'(e.cnt)) begin
            $display("%0t: pair_count exp %0d got %0d", $time, e.cnt, m_axis_tdata[10:0]);
            mismatches++;
          end
          if (m_axis_tdata[26:11] != e.mx) begin
            $display("%0t: mean_x exp %h got %h", $time, e.mx, m_axis_tdata[26:11]);
            mismatches++;
          end
          if (m_axis_tdata[42:27] != e.my) begin
            $display("%0t: mean_y exp %h got %h", $time, e.my, m_axis_tdata[42:27]);
            mismatches++;
          end
          if (m_axis_tdata[74:43] != e.cov) begin
            $display("%0t: covariance exp %h got %h", $time, e.cov, m_axis_tdata[74:43]);
            mismatches++;
          end
          if (m_axis_tdata[90:75] != e.corr) begin
            $display("%0t: correlation exp %h got %h", $time, e.corr, m_axis_tdata[90:75]);
            mismatches++;
          end
          if (m_axis_tuser != e.degen) begin
            $display("%0t: degenerate exp %b got %b", $time, e.degen, m_axis_tuser);
            mismatches++;
          end
        end
      end
      cyc++;
      if (cyc % 500 == 0) stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 80);
      if (hold_req > 0) begin
        hold_cnt = hold_req;
        hold_req = 0;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle = 0;
      else idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // test sequence
  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    pair_cnt = 0;
    acc_x = 0; acc_y = 0; acc_xy = 0; acc_xx = 0; acc_yy = 0;
    mismatches = 0;
    words_sent = 0;
    sets_checked = 0;
    degen_seen = 0;
    burst_left = 0;
    hold_req = 0;
    no_gaps = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_pair_limit();
    test_backpressure();
    test_random();
    s_axis_tvalid <= 1'b0;
    s_axis_tlast <= 1'b0;
    wait (expected_results.size() == 0);
    repeat (400) @(posedge clk_i);
    if (expected_results.size() != 0) mismatches++;
    $display("Sent %0d pairs; checked %0d data sets, %0d of them degenerate.",
             words_sent, sets_checked, degen_seen);
    $display("Covered extremes, r = +/-1, zero variance, the pair limit and a long output stall.");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### filelist.f
sv/pce_pkg.sv
sv/pce_front.sv
sv/pce_queue.sv
sv/pce_div.sv
sv/pce_back.sv
sv/pearson_correlation_engine.sv
sv/pce_checker.sv
bench/tb_pearson_correlation_engine.sv
